// ----- sv/rmq_pkg.sv -----
// Shared constants for the rotation matrix to quaternion converter.
`default_nettype none

package rmq_pkg;

    // Number of quaternion lanes carried through the pipeline.
    localparam int NUM_LANES = 4;

    // Number of matrix entries in one request.
    localparam int NUM_ENTRIES = 9;

    // Largest lane magnitude width that enters the normalizer.
    localparam int MAG_LIMIT = 30;

endpackage

`default_nettype wire

// ----- sv/rotation_matrix_to_quaternion.sv -----
// Rotation matrix to unit quaternion converter, fully pipelined.
//
// The slave channel (s_tvalid, s_tready, s_tdata) takes one 3x3 rotation matrix per
// request, nine signed fixed-point entries with FRAC_BITS fraction bits. The master
// channel (m_tvalid, m_tready, m_tdata, m_tuser) returns the unit quaternion
// (x, y, z, w) in the same format, with m_tuser set when the lanes were all zero and
// the identity was returned instead.
// One request enters every cycle while the output is not stalled; the depth is set
// by the bit-per-stage divider (2*FRAC_BITS+3 stages) and the bit-per-stage square
// root (FRAC_BITS+2 stages) that each lane passes through.
// Reset clears every valid bit, so the pipeline comes up empty with m_tvalid low.
// When the receiver holds m_tready low with a result waiting, the whole pipeline
// freezes and s_tready drops; no request is lost or repeated, and requests in
// flight move on again as soon as the result is taken. A new request is still
// accepted in the same cycle in which the waiting result is taken.
// Results are rounded to nearest with ties away from zero, exactly.
`default_nettype none

module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS  = 14,
    parameter int DATA_WIDTH = 16
) (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire logic                                          s_tvalid,
    output      logic                                          s_tready,
    // Fields from bit 0 up: col0_x, col0_y, col0_z, col1_x, col1_y, col1_z,
    // col2_x, col2_y, col2_z, then zero padding to whole bytes.
    input  wire logic [((rmq_pkg::NUM_ENTRIES*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
    output      logic                                          m_tvalid,
    input  wire logic                                          m_tready,
    // Fields from bit 0 up: quat_x, quat_y, quat_z, quat_w, then zero padding.
    output      logic [((rmq_pkg::NUM_LANES*DATA_WIDTH+7)/8)*8-1:0] m_tdata,
    // Field: degenerate.
    output      logic                                          m_tuser
);

    localparam int NL    = rmq_pkg::NUM_LANES;
    localparam int OUT_W = ((NL*DATA_WIDTH+7)/8)*8;
    // Lane width: holds the sums and 1.0 with headroom.
    localparam int LW    = ((DATA_WIDTH > FRAC_BITS) ? DATA_WIDTH : FRAC_BITS+1) + 3;
    localparam int SW    = (LW > rmq_pkg::MAG_LIMIT) ? rmq_pkg::MAG_LIMIT : LW;
    localparam int SHMAX = LW - SW;
    localparam int SQW   = 2*SW;
    localparam int SSW   = 2*SW + 2;
    localparam int REMW  = SSW + 1;
    localparam int QW    = 2*FRAC_BITS + 3;
    localparam int RW    = FRAC_BITS + 2;
    localparam int DW2   = 2*RW + 1;
    localparam int EW    = ((RW > DATA_WIDTH) ? RW : DATA_WIDTH) + 2;

    localparam logic [LW-1:0]  ONE_L  = LW'(1) << FRAC_BITS;
    localparam logic [DW2-1:0] ONE_W  = DW2'(1);
    localparam logic [EW-1:0]  MAXV_E = (EW'(1) << (DATA_WIDTH-1)) - EW'(1);
    localparam logic [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] ONE_Q = (FRAC_BITS >= DATA_WIDTH-1) ? MAXV
                                              : (DATA_WIDTH'(1) << FRAC_BITS);

    // Global advance: every stage moves when the output register can take data.
    logic adv;
    logic out_valid_reg;
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    // ------------------------------------------------------------------
    // Stage 0: lane sums and lane arrangement.
    logic signed [LW-1:0] e_in [rmq_pkg::NUM_ENTRIES];
    logic signed [LW-1:0] q_next [NL];
    logic                 v0_reg;
    logic signed [LW-1:0] q0_reg [NL];

    always_comb
    begin
        logic signed [LW-1:0] ux, uy, uz, vx, vy, vz, wx, wy, wz, t, tr;
        logic un, tn;
        for (int i = 0; i < rmq_pkg::NUM_ENTRIES; i++)
        begin
            e_in[i] = LW'($signed(s_tdata[i*DATA_WIDTH +: DATA_WIDTH]));
        end
        ux = e_in[0]; uy = e_in[1]; uz = e_in[2];
        vx = e_in[3]; vy = e_in[4]; vz = e_in[5];
        wx = e_in[6]; wy = e_in[7]; wz = e_in[8];
        un = ux[LW-1];
        t  = un ? (vy - wz) : (vy + wz);
        tn = t[LW-1];
        tr = un ? ($signed(ONE_L) - ux) : ($signed(ONE_L) + ux);
        case ({un, tn})
            2'b00:
            begin
                q_next[0] = vz - wy; q_next[1] = wx - uz;
                q_next[2] = uy - vx; q_next[3] = tr + t;
            end
            2'b01:
            begin
                q_next[0] = tr - t;  q_next[1] = uy + vx;
                q_next[2] = wx + uz; q_next[3] = vz - wy;
            end
            2'b10:
            begin
                q_next[0] = uy + vx; q_next[1] = tr + t;
                q_next[2] = vz + wy; q_next[3] = wx - uz;
            end
            default:
            begin
                q_next[0] = wx + uz; q_next[1] = vz + wy;
                q_next[2] = tr - t;  q_next[3] = uy - vx;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NL; i++)
            begin
                q0_reg[i] <= q_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: magnitudes, common scaling and squares.
    logic [LW-1:0]  mag [NL];
    logic [SW-1:0]  mag_sc [NL];
    logic [LW-1:0]  big;
    logic [5:0]     sh;
    logic           v1_reg;
    logic           deg1_reg;
    logic [NL-1:0]  neg1_reg;
    logic [SQW-1:0] sq1_reg [NL];

    always_comb
    begin
        big = '0;
        for (int i = 0; i < NL; i++)
        begin
            mag[i] = q0_reg[i][LW-1] ? LW'(-q0_reg[i]) : LW'(q0_reg[i]);
            if (mag[i] > big)
            begin
                big = mag[i];
            end
        end
        sh = '0;
        for (int k = 0; k < SHMAX; k++)
        begin
            if (((big >> k) >> rmq_pkg::MAG_LIMIT) != '0)
            begin
                sh = 6'(k + 1);
            end
        end
        for (int i = 0; i < NL; i++)
        begin
            mag_sc[i] = SW'(mag[i] >> sh);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            deg1_reg <= (big == '0);
            for (int i = 0; i < NL; i++)
            begin
                neg1_reg[i] <= q0_reg[i][LW-1];
                sq1_reg[i]  <= SQW'(mag_sc[i]) * SQW'(mag_sc[i]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: sum of squares.
    logic           v2_reg;
    logic           deg2_reg;
    logic [NL-1:0]  neg2_reg;
    logic [SQW-1:0] sq2_reg [NL];
    logic [SSW-1:0] ss2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            deg2_reg <= deg1_reg;
            neg2_reg <= neg1_reg;
            ss2_reg  <= SSW'(sq1_reg[0]) + SSW'(sq1_reg[1])
                      + SSW'(sq1_reg[2]) + SSW'(sq1_reg[3]);
            for (int i = 0; i < NL; i++)
            begin
                sq2_reg[i] <= sq1_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Divider: one quotient bit per stage of floor(mag^2 * 2^(2F+2) / ss).
    logic            div_vld_reg [QW];
    logic            div_deg_reg [QW];
    logic [NL-1:0]   div_neg_reg [QW];
    logic [SSW-1:0]  div_ss_reg  [QW];
    logic [REMW-1:0] div_rem_reg [QW][NL];
    logic [QW-1:0]   div_quo_reg [QW][NL];

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        logic [REMW-1:0] rem_in  [NL];
        logic [QW-1:0]   quo_in  [NL];
        logic [REMW-1:0] rem_out [NL];
        logic [QW-1:0]   quo_out [NL];
        logic [SSW-1:0]  ss_in;
        logic            vld_in;
        logic            deg_in;
        logic [NL-1:0]   neg_in;

        // Pick up the previous stage and take one restoring step per lane.
        always_comb
        begin
            if (k == 0)
            begin
                ss_in  = ss2_reg;
                vld_in = v2_reg;
                deg_in = deg2_reg;
                neg_in = neg2_reg;
            end
            else
            begin
                ss_in  = div_ss_reg[(k == 0) ? 0 : k-1];
                vld_in = div_vld_reg[(k == 0) ? 0 : k-1];
                deg_in = div_deg_reg[(k == 0) ? 0 : k-1];
                neg_in = div_neg_reg[(k == 0) ? 0 : k-1];
            end
            for (int i = 0; i < NL; i++)
            begin
                if (k == 0)
                begin
                    rem_in[i] = REMW'(sq2_reg[i]);
                    quo_in[i] = '0;
                end
                else
                begin
                    rem_in[i] = {div_rem_reg[(k == 0) ? 0 : k-1][i][REMW-2:0], 1'b0};
                    quo_in[i] = div_quo_reg[(k == 0) ? 0 : k-1][i];
                end
                if (rem_in[i] >= REMW'(ss_in))
                begin
                    rem_out[i] = rem_in[i] - REMW'(ss_in);
                    quo_out[i] = {quo_in[i][QW-2:0], 1'b1};
                end
                else
                begin
                    rem_out[i] = rem_in[i];
                    quo_out[i] = {quo_in[i][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                div_vld_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                div_vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                div_ss_reg[k]  <= ss_in;
                div_deg_reg[k] <= deg_in;
                div_neg_reg[k] <= neg_in;
                for (int i = 0; i < NL; i++)
                begin
                    div_rem_reg[k][i] <= rem_out[i];
                    div_quo_reg[k][i] <= quo_out[i];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Square root: one root bit per stage, most significant first.
    logic           sqr_vld_reg  [RW];
    logic           sqr_deg_reg  [RW];
    logic [NL-1:0]  sqr_neg_reg  [RW];
    logic [QW-1:0]  sqr_rem_reg  [RW][NL];
    logic [RW-1:0]  sqr_root_reg [RW][NL];

    for (genvar s = 0; s < RW; s++)
    begin : g_sqrt
        localparam int J = RW - 1 - s;
        logic [QW-1:0]  rem_in   [NL];
        logic [RW-1:0]  root_in  [NL];
        logic [QW-1:0]  rem_out  [NL];
        logic [RW-1:0]  root_out [NL];
        logic [DW2-1:0] delta    [NL];
        logic           vld_in;
        logic           deg_in;
        logic [NL-1:0]  neg_in;

        // Accept bit J when (root + 2^J)^2 still fits under the radicand.
        always_comb
        begin
            if (s == 0)
            begin
                vld_in = div_vld_reg[QW-1];
                deg_in = div_deg_reg[QW-1];
                neg_in = div_neg_reg[QW-1];
            end
            else
            begin
                vld_in = sqr_vld_reg[(s == 0) ? 0 : s-1];
                deg_in = sqr_deg_reg[(s == 0) ? 0 : s-1];
                neg_in = sqr_neg_reg[(s == 0) ? 0 : s-1];
            end
            for (int i = 0; i < NL; i++)
            begin
                if (s == 0)
                begin
                    rem_in[i]  = div_quo_reg[QW-1][i];
                    root_in[i] = '0;
                end
                else
                begin
                    rem_in[i]  = sqr_rem_reg[(s == 0) ? 0 : s-1][i];
                    root_in[i] = sqr_root_reg[(s == 0) ? 0 : s-1][i];
                end
                delta[i] = (DW2'(root_in[i]) << (J + 1)) + (ONE_W << (2*J));
                if (DW2'(rem_in[i]) >= delta[i])
                begin
                    rem_out[i]  = QW'(DW2'(rem_in[i]) - delta[i]);
                    root_out[i] = root_in[i] | (RW'(1) << J);
                end
                else
                begin
                    rem_out[i]  = rem_in[i];
                    root_out[i] = root_in[i];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sqr_vld_reg[s] <= 1'b0;
            end
            else if (adv)
            begin
                sqr_vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sqr_deg_reg[s] <= deg_in;
                sqr_neg_reg[s] <= neg_in;
                for (int i = 0; i < NL; i++)
                begin
                    sqr_rem_reg[s][i]  <= rem_out[i];
                    sqr_root_reg[s][i] <= root_out[i];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: round the half-step root, apply sign, saturate, and return the identity when degenerate.
    logic [DATA_WIDTH-1:0] comp_next [NL];
    logic [DATA_WIDTH-1:0] out_comp_reg [NL];
    logic                  out_deg_reg;

    // Root plus one for the round-to-nearest step; fits in RW bits.
    function automatic logic [RW-1:0] root_plus(input logic [RW-1:0] r);
        return r + RW'(1);
    endfunction

    always_comb
    begin
        logic [RW-1:0] lo;
        logic [EW-1:0] lo_e;
        for (int i = 0; i < NL; i++)
        begin
            lo   = RW'((root_plus(sqr_root_reg[RW-1][i])) >> 1);
            lo_e = EW'(lo);
            if (sqr_neg_reg[RW-1][i])
            begin
                if (lo_e > MAXV_E + EW'(1))
                begin
                    comp_next[i] = MINV;
                end
                else
                begin
                    comp_next[i] = DATA_WIDTH'(-lo_e);
                end
            end
            else
            begin
                if (lo_e > MAXV_E)
                begin
                    comp_next[i] = MAXV;
                end
                else
                begin
                    comp_next[i] = DATA_WIDTH'(lo_e);
                end
            end
            if (sqr_deg_reg[RW-1])
            begin
                comp_next[i] = (i == NL-1) ? ONE_Q : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= sqr_vld_reg[RW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_deg_reg <= sqr_deg_reg[RW-1];
            for (int i = 0; i < NL; i++)
            begin
                out_comp_reg[i] <= comp_next[i];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_deg_reg;
    assign m_tdata  = OUT_W'({out_comp_reg[3], out_comp_reg[2],
                              out_comp_reg[1], out_comp_reg[0]});

endmodule

`default_nettype wire
